// ----- src/field_subtoken_splitter_unit_defines.svh -----
// ----------------------------------------------------------------------------
// field_subtoken_splitter_unit_defines
// Assertion macros used by the subtoken splitter top level.
// ----------------------------------------------------------------------------
`ifndef FIELD_SUBTOKEN_SPLITTER_UNIT_DEFINES_SVH
`define FIELD_SUBTOKEN_SPLITTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FSP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FSP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/fsp_pkg.sv -----
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and constants shared by the field subtoken splitter modules.
// ----------------------------------------------------------------------------
package fsp_pkg;

	localparam int DEF_MAX_SUBTOKENS = 32;
	localparam int DEF_MAX_FIELD_LEN = 1024;

	// result field widths
	localparam int TOK_IDX_W = 5;
	localparam int TOK_LEN_W = 11;
	localparam int SEP_W     = 8;
	localparam int VALUE_W   = 63;
	localparam int ZP_W      = 10;
	localparam int TDATA_W   = 104;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_MID_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_MID_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT        = 3'd4;

	localparam logic [63:0] SEP_LOW_RST      = 64'd864831904598196738;
	localparam logic [63:0] SEP_MID_LOW_RST  = 64'd1152921506754330624;
	localparam logic [63:0] SEP_MID_HIGH_RST = 64'd0;
	localparam logic [63:0] SEP_HIGH_RST     = 64'd0;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NONE  = 8'h00;

	// largest accumulator that still takes one more digit up to 7
	localparam logic [VALUE_W-1:0] INT_LIM = 63'd922337203685477580;

	localparam int OUTQ_DEPTH = 4;

	typedef struct packed {
		logic [TOK_IDX_W-1:0] token_index;
		logic [TOK_LEN_W-1:0] token_length;
		logic [SEP_W-1:0]     separator_code;
		logic                 double_space;
		logic                 is_integer;
		logic [VALUE_W-1:0]   int_value;
		logic [ZP_W-1:0]      zero_prefix;
		logic                 last_token;
	} fsp_result_t;

	// results produced by one word: vld[0] always fills before vld[1]
	typedef struct packed {
		logic [1:0]  vld;
		fsp_result_t res0;
		fsp_result_t res1;
	} fsp_push_t;

endpackage

// ----- src/field_subtoken_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// field_subtoken_splitter_unit
// Splits a byte-streamed text field into subtokens and reports each one.
// ----------------------------------------------------------------------------
// Input stream s_axis: one field byte per word, tlast on the last byte of
// the field. Output stream m_axis: one word per subtoken, tlast on the final
// subtoken of the field. cfg: register writes, always ready; write only
// while the block is idle.
// Throughput: one byte per cycle. A byte is registered, then classified and
// folded into the open subtoken once the queue has room (one add of the
// times-ten accumulate and one compare); results enter a four-entry queue.
// A result is written into the queue as its byte leaves the input register.
// A space-ended subtoken is reported with the next byte; one byte yields
// zero, one or two results.
// Stall: while m_axis_tready is low the queue fills; s_axis_tready drops
// once fewer than two queue entries are free and one byte waits in the
// input register.
// Reset: separator set and split flag return to their defaults, the field
// state clears and the queue empties. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "field_subtoken_splitter_unit_defines.svh"

module field_subtoken_splitter_unit #(
	parameter int MAX_SUBTOKENS = fsp_pkg::DEF_MAX_SUBTOKENS,
	parameter int MAX_FIELD_LEN = fsp_pkg::DEF_MAX_FIELD_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // char_code
	input  logic                          s_axis_tlast,  // end_of_field
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// token_index, token_length, separator_code, double_space, is_integer,
	// int_value, zero_prefix, zero fill
	output logic [fsp_pkg::TDATA_W-1:0]   m_axis_tdata,
	output logic                          m_axis_tlast,  // last_token
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);
	import fsp_pkg::*;

	logic [255:0] sep_mask_q;
	logic         split_q;
	logic         room;
	fsp_push_t    push;
	fsp_result_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_mask_q <= {SEP_HIGH_RST, SEP_MID_HIGH_RST, SEP_MID_LOW_RST, SEP_LOW_RST};
			split_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEP_LOW:      sep_mask_q[63:0]    <= cfg_data;
				REG_SEP_MID_LOW:  sep_mask_q[127:64]  <= cfg_data;
				REG_SEP_MID_HIGH: sep_mask_q[191:128] <= cfg_data;
				REG_SEP_HIGH:     sep_mask_q[255:192] <= cfg_data;
				REG_SPLIT:        split_q             <= cfg_data[0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	fsp_token_core #(
		.MAX_SUBTOKENS(MAX_SUBTOKENS),
		.MAX_FIELD_LEN(MAX_FIELD_LEN)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tlast  (s_axis_tlast),
		.sep_mask (sep_mask_q),
		.split_en (split_q),
		.room     (room),
		.push     (push)
	);

	fsp_out_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (res)
	);

	assign m_axis_tdata = {5'b00000, res.zero_prefix, res.int_value, res.is_integer,
		res.double_space, res.separator_code, res.token_length, res.token_index};
	assign m_axis_tlast = res.last_token;

	`FSP_ASSERT_IMP(a_push_room, push.vld != 2'b00, room, "results pushed into a full queue")
	`FSP_ASSERT_IMP(a_push_order, push.vld[1], push.vld[0], "second result without a first")
	`FSP_ASSERT_IMP(a_stall_cause, !s_axis_tready, !room, "input stalled with queue room")
	`FSP_ASSERT_NXT(a_split_write, cfg_valid && cfg_ready && cfg_index == REG_SPLIT,
		split_q == $past(cfg_data[0]), "split flag write lost")

endmodule

// ----- src/fsp_token_core.sv -----
// ----------------------------------------------------------------------------
// fsp_token_core
// Input register and per-byte subtoken logic; emits up to two results a word.
// ----------------------------------------------------------------------------
module fsp_token_core #(
	parameter int MAX_SUBTOKENS = 32,
	parameter int MAX_FIELD_LEN = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	input  logic [255:0]       sep_mask,
	input  logic               split_en,
	input  logic               room,
	output fsp_pkg::fsp_push_t push
);
	import fsp_pkg::*;

	localparam int LEN_W = $clog2(MAX_FIELD_LEN + 1);
	localparam int CNT_W = $clog2(MAX_SUBTOKENS);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_FIELD_LEN);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SUBTOKENS - 1);

	typedef struct packed {
		logic [LEN_W-1:0]   len;
		logic               dclass;
		logic               all_dig;
		logic [VALUE_W-1:0] acc;
		logic               ovf;
		logic [LEN_W-1:0]   zrun;
		logic               zact;
	} tok_t;

	function automatic logic is_dig(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic tok_t tok_add(tok_t t, logic [7:0] c);
		tok_t               r;
		logic [3:0]         d;
		logic [VALUE_W-1:0] lim;
		logic [VALUE_W+2:0] prod;
		r    = t;
		d    = c[3:0];
		lim  = (d > 4'd7) ? INT_LIM - VALUE_W'(1) : INT_LIM;
		prod = ({3'b000, t.acc} << 3) + ({3'b000, t.acc} << 1) + (VALUE_W+3)'(d);
		if (r.len != LEN_MAX) begin
			r.len = r.len + LEN_W'(1);
		end
		if (is_dig(c)) begin
			if (!r.ovf) begin
				if (r.acc > lim) begin
					r.ovf = 1'b1;
				end else begin
					r.acc = prod[VALUE_W-1:0];
				end
			end
		end else begin
			r.all_dig = 1'b0;
		end
		if (r.zact) begin
			if (c == CH_ZERO) begin
				if (r.zrun != LEN_MAX) begin
					r.zrun = r.zrun + LEN_W'(1);
				end
			end else begin
				r.zact = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic tok_t tok_start(logic [7:0] c);
		tok_t t;
		t.len     = '0;
		t.dclass  = is_dig(c);
		t.all_dig = 1'b1;
		t.acc     = '0;
		t.ovf     = 1'b0;
		t.zrun    = '0;
		t.zact    = 1'b1;
		return tok_add(t, c);
	endfunction

	function automatic fsp_result_t tok_capture(tok_t t, logic [7:0] sep,
			logic [CNT_W-1:0] idx, logic last);
		fsp_result_t      r;
		logic             intg;
		logic [LEN_W-1:0] lz;
		intg = t.all_dig & ~t.ovf;
		lz   = '0;
		if (intg) begin
			lz = (t.zrun < t.len) ? t.zrun : t.len - LEN_W'(1);
		end
		r.token_index    = TOK_IDX_W'(idx);
		r.token_length   = TOK_LEN_W'(t.len);
		r.separator_code = sep;
		r.double_space   = 1'b0;
		r.is_integer     = intg;
		r.int_value      = intg ? t.acc : '0;
		r.zero_prefix    = ZP_W'(lz);
		r.last_token     = last;
		return r;
	endfunction

	function automatic fsp_push_t push_add(fsp_push_t p, fsp_result_t r);
		fsp_push_t q;
		q = p;
		if (!q.vld[0]) begin
			q.res0   = r;
			q.vld[0] = 1'b1;
		end else begin
			q.res1   = r;
			q.vld[1] = 1'b1;
		end
		return q;
	endfunction

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eof_s1;

	// field state
	tok_t             tok_q, tok_d;
	logic             open_q, open_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             pend_q, pend_d;
	fsp_result_t      pres_q, pres_d;

	logic        go;
	logic        c_dig;
	logic        sep_hit;
	logic        ends;
	logic        fld_end;
	logic        cont;
	tok_t        tok_added;
	tok_t        tok_started;
	fsp_result_t pend_out;

	assign go       = valid_s1 & room;
	assign s_tready = ~valid_s1 | go;

	assign c_dig       = is_dig(char_s1);
	assign sep_hit     = sep_mask[char_s1];
	assign ends        = (cnt_q < CNT_LAST) &&
		((split_en && (tok_q.dclass != c_dig)) || sep_hit);
	assign tok_added   = tok_add(tok_q, char_s1);
	assign tok_started = tok_start(char_s1);

	always_comb begin
		pend_out              = pres_q;
		pend_out.double_space = (char_s1 == CH_SPACE);
		pend_out.last_token   = (char_s1 == CH_SPACE) & eof_s1;
	end

	always_comb begin
		push    = '0;
		tok_d   = tok_q;
		open_d  = open_q;
		cnt_d   = cnt_q;
		pend_d  = pend_q;
		pres_d  = pres_q;
		fld_end = 1'b0;
		cont    = 1'b1;
		if (go) begin
			// a space-ended subtoken waits for this byte to settle double_space
			if (pend_q) begin
				pend_d = 1'b0;
				push   = push_add(push, pend_out);
				if (char_s1 == CH_SPACE) begin
					cont    = 1'b0;
					fld_end = eof_s1;
				end
			end
			if (cont) begin
				if (!open_q) begin
					tok_d  = tok_started;
					open_d = 1'b1;
					if (eof_s1) begin
						push    = push_add(push, tok_capture(tok_started, CH_NONE, cnt_q, 1'b1));
						fld_end = 1'b1;
					end
				end else if (!ends) begin
					tok_d = tok_added;
					if (eof_s1) begin
						push    = push_add(push, tok_capture(tok_added, CH_NONE, cnt_q, 1'b1));
						fld_end = 1'b1;
					end
				end else if (sep_hit && (char_s1 != CH_NONE)) begin
					// consume the separator
					cnt_d  = cnt_q + CNT_W'(1);
					open_d = 1'b0;
					if (eof_s1) begin
						push    = push_add(push, tok_capture(tok_q, char_s1, cnt_q, 1'b1));
						fld_end = 1'b1;
					end else if (char_s1 == CH_SPACE) begin
						pend_d = 1'b1;
						pres_d = tok_capture(tok_q, char_s1, cnt_q, 1'b0);
					end else begin
						push = push_add(push, tok_capture(tok_q, char_s1, cnt_q, 1'b0));
					end
				end else begin
					// boundary without a consumed separator: this byte opens the next one
					cnt_d  = cnt_q + CNT_W'(1);
					tok_d  = tok_started;
					open_d = 1'b1;
					push   = push_add(push, tok_capture(tok_q, CH_NONE, cnt_q, 1'b0));
					if (eof_s1) begin
						push    = push_add(push, tok_capture(tok_started, CH_NONE,
							cnt_q + CNT_W'(1), 1'b1));
						fld_end = 1'b1;
					end
				end
			end
			if (fld_end) begin
				cnt_d  = '0;
				open_d = 1'b0;
				pend_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			open_q   <= 1'b0;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			open_q <= open_d;
			cnt_q  <= cnt_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
		tok_q  <= tok_d;
		pres_q <= pres_d;
	end

endmodule

// ----- src/fsp_out_queue.sv -----
// ----------------------------------------------------------------------------
// fsp_out_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module fsp_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsp_pkg::fsp_push_t   push,
	output logic                 room,
	output logic                 m_valid,
	input  logic                 m_ready,
	output fsp_pkg::fsp_result_t m_res
);
	import fsp_pkg::*;

	localparam int PTR_W = $clog2(OUTQ_DEPTH);
	localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

	fsp_result_t      mem_q [OUTQ_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       n_push;
	logic             pop;

	assign n_push  = {1'b0, push.vld[1]} + {1'b0, push.vld[0]};
	assign pop     = m_valid & m_ready;
	assign m_valid = (cnt_q != '0);
	assign m_res   = mem_q[rd_q];
	// leave space for the two results one byte can produce
	assign room    = (cnt_q <= CNT_W'(OUTQ_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.vld[0]) begin
			mem_q[wr_q] <= push.res0;
		end
		if (push.vld[1]) begin
			mem_q[wr_q + PTR_W'(1)] <= push.res1;
		end
	end

endmodule
